// ===== src/lbps_pkg.sv =====
// Shared types and constants of the LED blink pattern sequencer.
package lbps_pkg;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_BYTE = 2'd1,
		MODE_EOL  = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STEP_RED   = 2'd0,
		STEP_GREEN = 2'd1,
		STEP_BOTH  = 2'd2,
		STEP_NONE  = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		STAT_NONE     = 2'd0,
		STAT_ACCEPTED = 2'd1,
		STAT_REJECTED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_PER_FIRST = 3'd0,
		PH_PER       = 3'd1,
		PH_REP_FIRST = 3'd2,
		PH_REP       = 3'd3,
		PH_STEPS     = 3'd4,
		PH_CNT_FIRST = 3'd5,
		PH_CNT       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_FILL,
		ST_DONE
	} state_t;

	localparam int unsigned IDLE_LENGTH   = 100;
	localparam logic [15:0] NUM_MAX       = 16'hFFFF;
	// Reciprocal of ten scaled by 2^19; exact for all 16-bit dividends.
	localparam logic [15:0] RECIP_TEN     = 16'd52429;
	localparam logic [9:0]  PWM_RESET     = 10'd64;

	function automatic logic is_step_char(input logic [7:0] ch);
		return ch == "r" || ch == "R" || ch == "g" || ch == "G" ||
			ch == "b" || ch == "B" || ch == "n" || ch == "N";
	endfunction

	function automatic step_t step_of(input logic [7:0] ch);
		step_t code;
		code = STEP_NONE;
		if (ch == "r" || ch == "R") code = STEP_RED;
		else if (ch == "g" || ch == "G") code = STEP_GREEN;
		else if (ch == "b" || ch == "B") code = STEP_BOTH;
		return code;
	endfunction

endpackage

// ===== src/lbps_in_if.sv =====
// Input channel of the sequencer: one event word per handshake.
interface lbps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] char_byte;
	modport source (output valid, output mode, output char_byte, input ready);
	modport sink (input valid, input mode, input char_byte, output ready);
endinterface

// ===== src/lbps_out_if.sv =====
// Output channel of the sequencer: one status word per handshake.
interface lbps_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] red_duty;
	logic [9:0] green_duty;
	logic [1:0] parse_status;
	logic       idle_playing;
	modport source (output valid, output red_duty, output green_duty,
		output parse_status, output idle_playing, input ready);
	modport sink (input valid, input red_duty, input green_duty,
		input parse_status, input idle_playing, output ready);
endinterface

// ===== src/led_blink_pattern_sequencer.sv =====
// Top level of the LED blink pattern sequencer.
//
// Every input word gives exactly one output word. A tick or a plain command byte passes
// through the done state on its way to the output register, and through the apply state
// first when a step is played, for the synchronous read of the pattern memory. An X run
// writes its copies one per cycle through the single write port in the fill state, before
// its closing letter moves on to the done state. Input is taken again the cycle after the
// output register is loaded, so the block takes no new word before the last one is
// through; a finished word that cannot leave holds the block until the output register
// drains. The pattern memory holds two banks and needs no clearing pass.
module led_blink_pattern_sequencer #(
	parameter int unsigned MAX_STEPS = 256,
	parameter int unsigned DUTY_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [9:0]        cfg_wdata,
	lbps_in_if.sink           in_ch,
	lbps_out_if.source        out_ch
);
	import lbps_pkg::*;

	localparam int unsigned IW = $clog2(MAX_STEPS);
	localparam int unsigned LW = $clog2(MAX_STEPS + 1);
	localparam int unsigned AW = IW + 1;
	localparam logic [9:0] DUTY_MASK = 10'((64'd1 << DUTY_BITS) - 64'd1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_STEPS);
	localparam logic [LW-1:0] IDLE_LEN = LW'(IDLE_LENGTH);

	logic [1:0] mem [2**AW];
	logic [1:0] rd_s1;

	state_t state_q, state_d;

	logic [9:0]    pwm_q;
	logic          bank_q;
	logic [LW-1:0] len_q, play_q;
	logic [12:0]   period_q, tdiv_q;
	logic [15:0]   rep_q, iter_q;
	logic [9:0]    red_q, green_q;
	logic          idle_q;
	phase_t        phase_q;
	logic [15:0]   num_q, sper_q, srep_q;
	logic [LW-1:0] slen_q, fill_q;
	step_t         fill_code_q;
	logic          failed_q;
	status_t       status_q;
	logic          first_s1;

	logic          out_valid_q;
	logic [9:0]    out_red_q, out_green_q;
	status_t       out_stat_q;
	logic          out_idle_q;

	logic          accept;
	mode_t         mode;
	logic [7:0]    ch;
	logic          digit;
	logic [19:0]   num_next20;
	logic [15:0]   num_sat;
	logic [13:0]   div_sum;
	logic          period_hit, wrap, go_idle, play_now;
	logic [LW-1:0] pi_eff;
	logic [16:0]   run_end;
	logic [31:0]   prod;
	logic          we;
	logic [AW-1:0] waddr;
	step_t         wdata;
	logic [9:0]    lit;

	assign accept = in_ch.valid && in_ch.ready;
	assign mode = mode_t'(in_ch.mode);
	assign ch = in_ch.char_byte;
	assign digit = ch >= "0" && ch <= "9";
	assign num_next20 = {4'd0, num_q} * 20'd10 + {16'd0, ch[3:0]};
	assign num_sat = (num_next20 > {4'd0, NUM_MAX}) ? NUM_MAX : num_next20[15:0];
	assign lit = pwm_q & DUTY_MASK;
	assign prod = sper_q * RECIP_TEN;
	assign run_end = {1'b0, num_q} + 17'(slen_q);

	// Tick decode.
	assign div_sum = {1'b0, tdiv_q} + 14'd1;
	assign period_hit = div_sum >= {1'b0, period_q};
	assign wrap = play_q >= len_q;
	assign go_idle = period_hit && wrap && (rep_q != 16'd0) && (iter_q >= rep_q);
	assign pi_eff = wrap ? '0 : play_q;
	assign play_now = period_hit && !go_idle && (pi_eff < len_q);

	// Staging writes to the bank that is not playing.
	always_comb begin
		we = 1'b0;
		waddr = {~bank_q, slen_q[IW-1:0]};
		wdata = step_of(ch);
		if (state_q == ST_FILL) begin
			we = 1'b1;
			wdata = fill_code_q;
		end else if (accept && mode == MODE_BYTE && ch != 8'd0 && !failed_q &&
				phase_q == PH_STEPS && slen_q < MAX_LEN && is_step_char(ch)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[{bank_q, pi_eff[IW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = ST_DONE;
					if (mode == MODE_TICK && play_now) state_d = ST_APPLY;
					if (mode == MODE_BYTE && ch != 8'd0 && !failed_q &&
							phase_q == PH_CNT && !digit && is_step_char(ch) &&
							run_end <= 17'(MAX_LEN) && num_q != 16'd0)
						state_d = ST_FILL;
				end
			end
			ST_APPLY: state_d = ST_DONE;
			ST_FILL: if (fill_q == LW'(1)) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q <= PWM_RESET;
			bank_q <= 1'b0;
			len_q <= '0;
			play_q <= '0;
			period_q <= 13'd1;
			rep_q <= 16'd1;
			iter_q <= '0;
			tdiv_q <= '0;
			red_q <= '0;
			green_q <= '0;
			idle_q <= 1'b0;
			phase_q <= PH_PER_FIRST;
			num_q <= '0;
			sper_q <= '0;
			srep_q <= '0;
			slen_q <= '0;
			failed_q <= 1'b0;
			fill_q <= '0;
			fill_code_q <= STEP_NONE;
			status_q <= STAT_NONE;
			first_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_red_q <= '0;
			out_green_q <= '0;
			out_stat_q <= STAT_NONE;
			out_idle_q <= 1'b0;
		end else begin
			if (cfg_we) pwm_q <= cfg_wdata;
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_EOL || (mode == MODE_BYTE && ch == 8'd0))
							status_q <= (!failed_q && phase_q == PH_STEPS) ?
								STAT_ACCEPTED : STAT_REJECTED;
						else status_q <= STAT_NONE;
						if (mode == MODE_TICK) begin
							if (period_hit) begin
								tdiv_q <= '0;
								if (go_idle) begin
									play_q <= pi_eff;
									red_q <= '0;
									green_q <= '0;
									period_q <= 13'd1;
									rep_q <= '0;
									iter_q <= '0;
									len_q <= IDLE_LEN;
									idle_q <= 1'b1;
								end else begin
									if (wrap && rep_q != 16'd0) iter_q <= iter_q + 16'd1;
									if (play_now) play_q <= pi_eff + LW'(1);
									else play_q <= pi_eff;
								end
								first_s1 <= pi_eff == '0;
							end else tdiv_q <= div_sum[12:0];
						end else if (mode == MODE_EOL || (mode == MODE_BYTE && ch == 8'd0)) begin
							if (!failed_q && phase_q == PH_STEPS) begin
								bank_q <= ~bank_q;
								len_q <= slen_q;
								play_q <= '0;
								period_q <= prod[31:19];
								rep_q <= srep_q;
								iter_q <= '0;
								idle_q <= 1'b0;
							end
							phase_q <= PH_PER_FIRST;
							num_q <= '0;
							sper_q <= '0;
							srep_q <= '0;
							slen_q <= '0;
							failed_q <= 1'b0;
						end else if (mode == MODE_BYTE && !failed_q) begin
							case (phase_q)
								PH_PER_FIRST, PH_REP_FIRST, PH_CNT_FIRST: begin
									if (!digit) failed_q <= 1'b1;
									else begin
										num_q <= {12'd0, ch[3:0]};
										phase_q <= phase_t'(phase_q + 3'd1);
									end
								end
								PH_PER: begin
									if (digit) num_q <= num_sat;
									else if (num_q == 16'd0 || (ch != "r" && ch != "R"))
										failed_q <= 1'b1;
									else begin
										sper_q <= num_q;
										phase_q <= PH_REP_FIRST;
									end
								end
								PH_REP: begin
									if (digit) num_q <= num_sat;
									else if (ch != "s" && ch != "S") failed_q <= 1'b1;
									else begin
										srep_q <= num_q;
										phase_q <= PH_STEPS;
									end
								end
								PH_STEPS: begin
									if (slen_q >= MAX_LEN) failed_q <= 1'b1;
									else if (ch == "x" || ch == "X") phase_q <= PH_CNT_FIRST;
									else if (!is_step_char(ch)) failed_q <= 1'b1;
									else slen_q <= slen_q + LW'(1);
								end
								PH_CNT: begin
									if (digit) num_q <= num_sat;
									else if (!is_step_char(ch) || run_end > 17'(MAX_LEN))
										failed_q <= 1'b1;
									else begin
										fill_q <= num_q[LW-1:0];
										fill_code_q <= step_of(ch);
										phase_q <= PH_STEPS;
									end
								end
								default: failed_q <= 1'b1;
							endcase
						end
					end
				end
				ST_APPLY: begin
					case (idle_q ? (first_s1 ? STEP_GREEN : STEP_NONE) : step_t'(rd_s1))
						STEP_RED: begin
							red_q <= lit;
							green_q <= '0;
						end
						STEP_GREEN: begin
							red_q <= '0;
							green_q <= lit;
						end
						STEP_BOTH: begin
							red_q <= lit;
							green_q <= lit;
						end
						default: begin
							red_q <= '0;
							green_q <= '0;
						end
					endcase
				end
				ST_FILL: begin
					slen_q <= slen_q + LW'(1);
					fill_q <= fill_q - LW'(1);
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_red_q <= red_q;
						out_green_q <= green_q;
						out_stat_q <= status_q;
						out_idle_q <= idle_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.red_duty = out_red_q;
	assign out_ch.green_duty = out_green_q;
	assign out_ch.parse_status = out_stat_q;
	assign out_ch.idle_playing = out_idle_q;

endmodule

// ===== tb/lbps_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench copies of the sequencer channel interfaces are not needed; this file holds the event and duty word types.
package lbps_tb_pkg;
	import lbps_pkg::*;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] char_byte;
	} event_word_t;

	typedef struct packed {
		logic [9:0] red_duty;
		logic [9:0] green_duty;
		logic [1:0] parse_status;
		logic       idle_playing;
	} duty_word_t;
endpackage

// ===== tb/tb_led_blink_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the LED blink pattern sequencer.
module tb_led_blink_pattern_sequencer;
	import lbps_pkg::*;
	import lbps_tb_pkg::*;

	localparam int unsigned STEPS = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [9:0] cfg_wdata = '0;

	lbps_in_if in_ch ();
	lbps_out_if out_ch ();

	led_blink_pattern_sequencer u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [1:0]  bank_mem [0:2*STEPS-1];
	logic        cur_bank;
	int unsigned cur_len, play_pos, period, rep_goal, rep_done, div_cnt;
	logic [9:0]  red_lvl, green_lvl, lit_level;
	logic        idle_on;
	int unsigned phase, number, st_period, st_repeats, st_len;
	logic        failed;

	event_word_t pending_words[$];
	duty_word_t  expected_duties[$];
	int          mismatches = 0;
	int          hold_off = 0;
	bit          long_hold_req = 0;

	function automatic int step_of_char(input logic [7:0] ch);
		if (ch == "r" || ch == "R") return STEP_RED;
		if (ch == "g" || ch == "G") return STEP_GREEN;
		if (ch == "b" || ch == "B") return STEP_BOTH;
		if (ch == "n" || ch == "N") return STEP_NONE;
		return -1;
	endfunction

	task automatic restart_parser();
		phase = PH_PER_FIRST; number = 0; st_period = 0; st_repeats = 0;
		st_len = 0; failed = 0;
	endtask

	task automatic add_digit(input logic [7:0] ch);
		number = number * 10 + (ch - "0");
		if (number > 65535) number = 65535;
	endtask

	task automatic stage_step(input int code);
		if (st_len < STEPS) bank_mem[{~cur_bank, 8'(st_len)}] = code[1:0];
		st_len++;
	endtask

	task automatic parse_char(input logic [7:0] ch);
		bit digit;
		int code;
		digit = ch >= "0" && ch <= "9";
		if (failed) return;
		case (phase)
			PH_PER_FIRST, PH_REP_FIRST, PH_CNT_FIRST: begin
				if (!digit) begin failed = 1; return; end
				number = ch - "0";
				phase++;
			end
			PH_PER: begin
				if (digit) add_digit(ch);
				else if (number == 0 || (ch != "r" && ch != "R")) failed = 1;
				else begin st_period = number; phase = PH_REP_FIRST; end
			end
			PH_REP: begin
				if (digit) add_digit(ch);
				else if (ch != "s" && ch != "S") failed = 1;
				else begin st_repeats = number; phase = PH_STEPS; end
			end
			PH_STEPS: begin
				code = step_of_char(ch);
				if (st_len >= STEPS) failed = 1;
				else if (ch == "x" || ch == "X") phase = PH_CNT_FIRST;
				else if (code < 0) failed = 1;
				else stage_step(code);
			end
			PH_CNT: begin
				code = step_of_char(ch);
				if (digit) add_digit(ch);
				else if (code < 0 || st_len + number > STEPS) failed = 1;
				else begin
					for (int k = 0; k < number; k++) stage_step(code);
					phase = PH_STEPS;
				end
			end
			default: failed = 1;
		endcase
	endtask

	task automatic advance_tick();
		int code;
		div_cnt++;
		if (div_cnt < period) return;
		div_cnt = 0;
		if (play_pos >= cur_len) begin
			play_pos = 0;
			if (rep_goal > 0) begin
				if (rep_done >= rep_goal) begin
					red_lvl = 0; green_lvl = 0; period = 1; rep_goal = 0;
					rep_done = 0; cur_len = IDLE_LENGTH; idle_on = 1;
					return;
				end
				rep_done++;
			end
		end
		if (play_pos >= cur_len) return;
		if (idle_on) code = play_pos == 0 ? STEP_GREEN : STEP_NONE;
		else code = bank_mem[{cur_bank, 8'(play_pos)}];
		play_pos++;
		case (code)
			STEP_RED: begin red_lvl = lit_level; green_lvl = 0; end
			STEP_GREEN: begin red_lvl = 0; green_lvl = lit_level; end
			STEP_BOTH: begin red_lvl = lit_level; green_lvl = lit_level; end
			default: begin red_lvl = 0; green_lvl = 0; end
		endcase
	endtask

	task automatic predict_duty(input event_word_t w, output duty_word_t r);
		logic [1:0] stat;
		stat = STAT_NONE;
		if (w.mode == MODE_TICK) advance_tick();
		else if (w.mode == MODE_EOL || (w.mode == MODE_BYTE && w.char_byte == 8'd0)) begin
			stat = STAT_REJECTED;
			if (!failed && phase == PH_STEPS) begin
				cur_bank = ~cur_bank; cur_len = st_len; play_pos = 0;
				period = st_period / 10; rep_goal = st_repeats; rep_done = 0;
				idle_on = 0; stat = STAT_ACCEPTED;
			end
			restart_parser();
		end else if (w.mode == MODE_BYTE) parse_char(w.char_byte);
		r.red_duty = red_lvl; r.green_duty = green_lvl;
		r.parse_status = stat; r.idle_playing = idle_on;
	endtask

	// Driver: one word at a time from the pending queue, random gaps.
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= MODE_TICK;
			in_ch.char_byte <= '0;
		end else if (in_ch.valid && !in_ch.ready) begin
		end else if (gap > 0) begin
			gap <= gap - 1;
			in_ch.valid <= 1'b0;
		end else if (pending_words.size() > 0) begin
			event_word_t w;
			duty_word_t exp_d;
			w = pending_words.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.mode <= w.mode;
			in_ch.char_byte <= w.char_byte;
			predict_duty(w, exp_d);
			expected_duties.push_back(exp_d);
			gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		end else in_ch.valid <= 1'b0;
	end

	// Monitor with random stalls and one long hold-off.
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				duty_word_t got, exp_w;
				got = {out_ch.red_duty, out_ch.green_duty, out_ch.parse_status,
					out_ch.idle_playing};
				if (expected_duties.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", got);
				end else begin
					exp_w = expected_duties.pop_front();
					if (got !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected r=%0d g=%0d st=%0d idle=%0d, got r=%0d g=%0d st=%0d idle=%0d",
								exp_w.red_duty, exp_w.green_duty, exp_w.parse_status,
								exp_w.idle_playing, got.red_duty, got.green_duty,
								got.parse_status, got.idle_playing);
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req <= 0;
				hold_off <= 200;
				out_ch.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (out_ch.valid)
					stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			end
		end
	end

	task automatic push_byte(input logic [7:0] ch);
		pending_words.push_back('{MODE_BYTE, ch});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++) pending_words.push_back('{MODE_TICK, 8'($urandom)});
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || expected_duties.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_level(input logic [9:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_wdata <= v; lit_level = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_char();
		string pool;
		pool = "0123456789rRgGbBnNsSxXzq";
		case ($urandom_range(0, 5))
			0: return 8'($urandom);
			default: return pool[$urandom_range(0, pool.len() - 1)];
		endcase
	endfunction

	// One well-formed line with random content, sometimes broken.
	task automatic push_random_line();
		string steps_s;
		int n;
		steps_s = "SRNGBgrbn";
		push_text($sformatf("%0dR%0dS", $urandom_range(0, 3) == 0 ? $urandom_range(1, 99999)
			: $urandom_range(1, 40), $urandom_range(0, 3)));
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				int c;
				c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom_range(1, 6);
				push_text($sformatf("x%0d", c));
				push_byte(steps_s[$urandom_range(1, 8)]);
			end else push_byte(steps_s[$urandom_range(1, 8)]);
		end
		if ($urandom_range(0, 7) == 0) push_byte(random_char());
		if ($urandom_range(0, 1)) pending_words.push_back('{MODE_EOL, 8'($urandom)});
		else push_byte(8'd0);
		push_ticks($urandom_range(2, 25));
	endtask

	initial begin
		for (int i = 0; i < 2 * STEPS; i++) bank_mem[i] = STEP_NONE;
		cur_bank = 0; cur_len = 0; play_pos = 0; period = 1; rep_goal = 1;
		rep_done = 0; div_cnt = 0; red_lvl = 0; green_lvl = 0; idle_on = 0;
		lit_level = PWM_RESET;
		restart_parser();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: start-up idle, basic line, saturation, X runs, rejections.
		push_ticks(4);
		pending_words.push_back('{MODE_NOP, 8'hFF});
		push_text("5R2SrgbN"); push_byte(8'd0); push_ticks(12);
		push_text("999999R0SX3gXr"); pending_words.push_back('{MODE_EOL, 8'h00});
		push_text("0R1Sr"); pending_words.push_back('{MODE_EOL, 8'hFF});
		pending_words.push_back('{MODE_EOL, 8'h00});
		push_text("20R1SX256b"); push_byte(8'd0); push_ticks(6);
		push_text("10R1SX257b"); push_byte(8'd0);
		push_text("10R1SX256br"); push_byte(8'd0);
		push_text("10R1SX2"); push_byte(8'd0);
		drain();
		write_level(10'd1023);
		push_text("1R1SrgbN"); push_byte(8'd0); push_ticks(10);
		drain();
		write_level(10'd0);
		push_text("30R1Sgr"); push_byte(8'd0); push_ticks(12);
		drain();
		write_level(10'h2AA);

		// Long receiver hold-off while the sender keeps offering words.
		push_ticks(20);
		long_hold_req <= 1;
		drain();
		write_level(10'h155);
		while (pending_words.size() < 600) begin
			if ($urandom_range(0, 4) == 0) push_byte(random_char());
			else push_random_line();
			if (pending_words.size() > 350 && pending_words.size() < 380)
				push_ticks(120);
		end
		drain();
		if (mismatches == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
